>>> src/se2lej_pkg.sv
// ----------------------------------------------------------------------------
// se2lej_pkg
// shared constants and types for the range-bearing edge error pipeline
// ----------------------------------------------------------------------------
`default_nettype none
package se2lej_pkg;

  localparam int CORDIC_MAX = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef logic signed [33:0] cw_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'h20000000;   5'd1: r = 32'h12E4051E;
        5'd2: r = 32'h09FB385B;   5'd3: r = 32'h051111D4;
        5'd4: r = 32'h028B0D43;   5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E;   5'd7: r = 32'h00517C55;
        5'd8: r = 32'h0028BE53;   5'd9: r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

>>> src/se2lej_trig.sv
// ----------------------------------------------------------------------------
// se2lej_trig
// pipelined cordic cosine and sine of a 16-bit binary angle, Q2.14 out
// ----------------------------------------------------------------------------
`default_nettype none
module se2lej_trig #(
  parameter int STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic [15:0]        angle,
  output logic signed [15:0]      cos_q14,
  output logic signed [15:0]      sin_q14
);

  localparam int NS = (STAGES > se2lej_pkg::CORDIC_MAX) ? se2lej_pkg::CORDIC_MAX :
                      ((STAGES < 1) ? 1 : STAGES);

  se2lej_pkg::cw_t    xs [NS+1];
  se2lej_pkg::cw_t    ys [NS+1];
  logic signed [32:0] zs [NS+1];
  logic [1:0]         qs [NS+1];

  logic [31:0] a_full;
  logic [1:0]  q0;
  logic [31:0] ur;

  // quadrant reduction
  always_comb begin
    a_full = {angle, 16'd0};
    q0 = 2'((a_full + 32'h20000000) >> 30);
    ur = a_full - {q0, 30'd0};
  end

  always_ff @(posedge clk) begin
    xs[0] <= se2lej_pkg::CORDIC_GAIN;
    ys[0] <= '0;
    zs[0] <= 33'(signed'(ur));
    qs[0] <= q0;
  end

  // one rotation per register stage
  for (genvar i = 0; i < NS; i++) begin : g_st
    logic signed [32:0] at;
    assign at = 33'(se2lej_pkg::atan_turn(5'(i)));
    always_ff @(posedge clk) begin
      if (!zs[i][32]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - at;
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + at;
      end
      qs[i+1] <= qs[i];
    end
  end

  // round, clamp and restore quadrant
  logic signed [33:0] cr, sr;
  logic signed [15:0] c, s;
  always_comb begin
    cr = (xs[NS] + 34'sd32768) >>> 16;
    sr = (ys[NS] + 34'sd32768) >>> 16;
    c = (cr > 34'sd16384) ? 16'sd16384 : ((cr < -34'sd16384) ? -16'sd16384 : 16'(cr));
    s = (sr > 34'sd16384) ? 16'sd16384 : ((sr < -34'sd16384) ? -16'sd16384 : 16'(sr));
  end

  always_ff @(posedge clk) begin
    unique case (qs[NS])
      2'd0: begin cos_q14 <= c;  sin_q14 <= s;  end
      2'd1: begin cos_q14 <= -s; sin_q14 <= c;  end
      2'd2: begin cos_q14 <= -c; sin_q14 <= -s; end
      default: begin cos_q14 <= s; sin_q14 <= -c; end
    endcase
  end

endmodule
`default_nettype wire

>>> src/se2_landmark_edge_error_jacobian.sv
// ----------------------------------------------------------------------------
// se2_landmark_edge_error_jacobian
// range-bearing landmark edge: error and heading jacobian for a planar pose
// ----------------------------------------------------------------------------
// usage: raise start with one edge word on the input ports; busy is always
// low, so a word is taken on every cycle that start is high. each word gives
// one result word, shown for one cycle with done high; the receiver cannot
// stall and need not. the result is registered in these steps in order: angle
// reduction, the cordic rotation stages, quadrant restore, the 16 by 33 bit
// and 16 by 32 bit products, the sums, and rounding and saturation.
// throughput is one word per cycle, set by the fully pipelined cordic stages.
// reset clears the valid pipeline, so done stays low until fresh words arrive;
// payload registers are not reset. heading_cos and heading_sin are the pose
// and landmark jacobian entries up to sign.
// ----------------------------------------------------------------------------
`default_nettype none
module se2_landmark_edge_error_jacobian #(
  parameter int TRIG_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] robot_x,
  input  wire logic signed [31:0] robot_y,
  input  wire logic signed [15:0] robot_heading,
  input  wire logic signed [31:0] landmark_x,
  input  wire logic signed [31:0] landmark_y,
  input  wire logic [30:0]        meas_range,
  input  wire logic signed [15:0] meas_bearing,
  output logic                    done,
  output logic signed [31:0]      error_x,
  output logic signed [31:0]      error_y,
  output logic signed [31:0]      jac_heading_x,
  output logic signed [31:0]      jac_heading_y,
  output logic signed [15:0]      heading_cos,
  output logic signed [15:0]      heading_sin
);

  localparam int NS = (TRIG_STAGES > se2lej_pkg::CORDIC_MAX) ? se2lej_pkg::CORDIC_MAX :
                      ((TRIG_STAGES < 1) ? 1 : TRIG_STAGES);
  localparam int TL = NS + 2;
  localparam int DEPTH = TL + 3;

  assign busy = 1'b0;

  logic [DEPTH-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DEPTH-2:0], start};
    end
  end
  assign done = vld[DEPTH-1];

  logic signed [15:0] hc, hs, bc, bs;
  se2lej_trig #(.STAGES(TRIG_STAGES)) u_head (
    .clk(clk), .angle(robot_heading), .cos_q14(hc), .sin_q14(hs));
  se2lej_trig #(.STAGES(TRIG_STAGES)) u_bear (
    .clk(clk), .angle(meas_bearing), .cos_q14(bc), .sin_q14(bs));

  // delay line for differences and range alongside the cordic
  logic signed [32:0] dxd [TL];
  logic signed [32:0] dyd [TL];
  logic [30:0]        rgd [TL];
  always_ff @(posedge clk) begin
    dxd[0] <= 33'(landmark_x) - 33'(robot_x);
    dyd[0] <= 33'(landmark_y) - 33'(robot_y);
    rgd[0] <= meas_range;
    for (int i = 1; i < TL; i++) begin
      dxd[i] <= dxd[i-1];
      dyd[i] <= dyd[i-1];
      rgd[i] <= rgd[i-1];
    end
  end

  // products
  logic signed [48:0] p_cx, p_sy, p_cy, p_sx, p_rc, p_rs;
  logic signed [15:0] hc1, hs1, hc2, hs2;
  always_ff @(posedge clk) begin
    p_cx <= 49'(hc) * 49'(dxd[TL-1]);
    p_sy <= 49'(hs) * 49'(dyd[TL-1]);
    p_cy <= 49'(hc) * 49'(dyd[TL-1]);
    p_sx <= 49'(hs) * 49'(dxd[TL-1]);
    p_rc <= 49'($signed({1'b0, rgd[TL-1]})) * 49'(bc);
    p_rs <= 49'($signed({1'b0, rgd[TL-1]})) * 49'(bs);
    hc1 <= hc;
    hs1 <= hs;
  end

  // sums
  logic signed [51:0] ex, ey, jx, jy;
  always_ff @(posedge clk) begin
    ex <= 52'(p_cx) + 52'(p_sy) - 52'(p_rc);
    ey <= 52'(p_cy) - 52'(p_sx) - 52'(p_rs);
    jx <= 52'(p_cy) - 52'(p_sx);
    jy <= -(52'(p_cx) + 52'(p_sy));
    hc2 <= hc1;
    hs2 <= hs1;
  end

  function automatic logic signed [31:0] sat(input logic signed [51:0] v);
    logic signed [51:0] r;
    begin
      r = (v + 52'sd8192) >>> 14;
      if (r > 52'sd2147483647) return 32'sh7FFFFFFF;
      else if (r < -52'sd2147483648) return 32'sh80000000;
      else return 32'(r);
    end
  endfunction

  // round and saturate
  always_ff @(posedge clk) begin
    error_x <= sat(ex);
    error_y <= sat(ey);
    jac_heading_x <= sat(jx);
    jac_heading_y <= sat(jy);
    heading_cos <= hc2;
    heading_sin <= hs2;
  end

endmodule
`default_nettype wire
